[design/assert_macros.svh]
// assertion macros used by the sequencer module of the scanner
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define LMRS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("lmrs assertion failed");

// expression must never be true outside reset
`define LMRS_ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("lmrs forbidden condition seen");

`else

`define LMRS_ASSERT(label, prop)
`define LMRS_ASSERT_NEVER(label, expr)

`endif

`endif

[design/lmrs_pkg.sv]
// shared types, constants and helpers of the led matrix refresh scanner
package lmrs_pkg;

   localparam int COLUMNS   = 16;
   localparam int BLOCKS    = 8;
   localparam int PAT_DEPTH = COLUMNS * BLOCKS;
   localparam int PAT_AW    = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
   localparam int COL_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int BLK_W     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int Q_DEPTH   = 4;
   localparam int Q_AW      = $clog2(Q_DEPTH);

   localparam int CMD_W  = 2;
   localparam int ADDR_W = 7;
   localparam int DATA_W = 8;
   localparam int KIND_W = 3;

   localparam logic [KIND_W-1:0] KIND_OFF   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SHIFT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_LATCH = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ON    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DELAY = 3'd4;

   typedef enum logic [CMD_W-1:0] {
      OP_TICK  = 2'd0,
      OP_DELAY = 2'd1,
      OP_PAT   = 2'd2,
      OP_CODE  = 2'd3
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   addr;
      logic [DATA_W-1:0]   data;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   // pattern store index of one block at one column
   function automatic logic [PAT_AW-1:0] pat_index(input logic [BLK_W-1:0] blk,
                                                   input logic [COL_W-1:0] col);
      return PAT_AW'(int'(blk) * COLUMNS + int'(col));
   endfunction

endpackage

[design/lmrs_ram.sv]
// generic single write port ram with registered read
module lmrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/lmrs_front.sv]
// request decode and filtering of out-of-range writes ahead of the queue
module lmrs_front (
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [lmrs_pkg::CMD_W-1:0]  req_command,
   input  logic [lmrs_pkg::ADDR_W-1:0] req_address,
   input  logic [lmrs_pkg::DATA_W-1:0] req_data,
   input  logic                       q_full,
   output lmrs_pkg::push_type         push
);

   lmrs_pkg::op_type op;
   logic             keep;

   always_comb begin
      op   = lmrs_pkg::op_type'(req_command);
      keep = 1'b1;
      unique case (op)
         lmrs_pkg::OP_PAT:  keep = int'(req_address) < lmrs_pkg::PAT_DEPTH;
         lmrs_pkg::OP_CODE: keep = int'(req_address) < lmrs_pkg::COLUMNS;
         default:           keep = 1'b1;
      endcase
   end

   assign req_stall        = q_full;
   assign push.push        = req_valid && !q_full && keep;
   assign push.entry.op    = op;
   assign push.entry.addr  = req_address;
   assign push.entry.data  = req_data;

endmodule

[design/lmrs_queue.sv]
// short request queue between the decode front and the sequencer
module lmrs_queue (
   input  logic                clock,
   input  logic                reset,
   input  lmrs_pkg::push_type  push,
   input  logic                pop,
   output logic                full,
   output lmrs_pkg::head_type  head
);

   lmrs_pkg::entry_type          slot_ff [lmrs_pkg::Q_DEPTH];
   logic [lmrs_pkg::Q_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [lmrs_pkg::Q_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [lmrs_pkg::Q_AW:0]      count_ff, count_in;
   logic                         do_push, do_pop;

   assign full    = count_ff == (lmrs_pkg::Q_AW + 1)'(lmrs_pkg::Q_DEPTH);
   assign do_push = push.push && !full;
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

   assign head.valid = count_ff != '0;
   assign head.entry = slot_ff[rd_ptr_ff];

endmodule

[design/lmrs_back.sv]
// refresh sequencer: stores, column state and the result register
`include "assert_macros.svh"

module lmrs_back (
   input  logic                        clock,
   input  logic                        reset,
   input  lmrs_pkg::head_type          head,
   output logic                        pop,
   input  logic                        dimmer_enable,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lmrs_pkg::KIND_W-1:0]  rsp_kind,
   output logic [lmrs_pkg::DATA_W-1:0]  rsp_shift_byte,
   output logic                        rsp_last
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_OFF   = 6'b000010,
      ST_SHIFT = 6'b000100,
      ST_CODE  = 6'b001000,
      ST_LATCH = 6'b010000,
      ST_FINAL = 6'b100000
   } state_type;

   state_type                        state_ff, state_in;
   logic [lmrs_pkg::BLK_W-1:0]       blk_ff, blk_in;
   logic [lmrs_pkg::COL_W-1:0]       col_ff, col_in;
   logic                             ready_ff, ready_in;
   logic                             dim_ff, dim_in;
   logic [lmrs_pkg::DATA_W-1:0]      code_ff [lmrs_pkg::COLUMNS];
   logic [lmrs_pkg::PAT_DEPTH-1:0]   pat_valid_ff;
   logic                             pv_ff;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [lmrs_pkg::KIND_W-1:0]      rsp_kind_ff;
   logic [lmrs_pkg::DATA_W-1:0]      rsp_byte_ff;
   logic                             rsp_last_ff;

   logic                             can_load, have, load;
   logic [lmrs_pkg::KIND_W-1:0]      res_kind;
   logic [lmrs_pkg::DATA_W-1:0]      res_byte;
   logic                             res_last;
   logic                             pat_we, code_we;
   logic [lmrs_pkg::PAT_AW-1:0]      rd_addr, wr_addr;
   logic [lmrs_pkg::DATA_W-1:0]      pat_data;

   assign can_load = !rsp_valid_ff || !rsp_stall;
   assign load     = have && can_load;
   assign wr_addr  = lmrs_pkg::PAT_AW'(head.entry.addr);

   always_comb begin
      state_in = state_ff;
      blk_in   = blk_ff;
      col_in   = col_ff;
      ready_in = ready_ff;
      dim_in   = dim_ff;
      pop      = 1'b0;
      have     = 1'b0;
      res_kind = lmrs_pkg::KIND_OFF;
      res_byte = '0;
      res_last = 1'b0;
      pat_we   = 1'b0;
      code_we  = 1'b0;
      rd_addr  = lmrs_pkg::pat_index(blk_ff, col_ff);
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = lmrs_pkg::pat_index('0, col_ff);
            if (head.valid) begin
               case (head.entry.op)
                  lmrs_pkg::OP_TICK: begin
                     pop = 1'b1;
                     if (ready_ff) begin
                        ready_in = 1'b0;
                        state_in = ST_OFF;
                     end
                  end
                  lmrs_pkg::OP_DELAY: begin
                     if (dim_ff) begin
                        have     = 1'b1;
                        res_kind = lmrs_pkg::KIND_ON;
                        res_last = 1'b1;
                        // hold the request until the result register takes it
                        if (can_load) begin
                           pop      = 1'b1;
                           dim_in   = 1'b0;
                           ready_in = 1'b1;
                        end
                     end else begin
                        pop = 1'b1;
                     end
                  end
                  lmrs_pkg::OP_PAT: begin
                     pop    = 1'b1;
                     pat_we = 1'b1;
                  end
                  default: begin
                     pop     = 1'b1;
                     code_we = 1'b1;
                  end
               endcase
            end
         end
         ST_OFF: begin
            have     = 1'b1;
            res_kind = lmrs_pkg::KIND_OFF;
            rd_addr  = lmrs_pkg::pat_index('0, col_ff);
            if (can_load) begin
               blk_in   = '0;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            have     = 1'b1;
            res_kind = lmrs_pkg::KIND_SHIFT;
            // never-written entries read as zero, inverted
            res_byte = pv_ff ? ~pat_data : '1;
            if (can_load) begin
               // fetch the next block so its byte is ready in the next cycle
               rd_addr = lmrs_pkg::pat_index(blk_ff + 1'b1, col_ff);
               if (blk_ff == lmrs_pkg::BLK_W'(lmrs_pkg::BLOCKS - 1)) begin
                  state_in = ST_CODE;
               end else begin
                  blk_in = blk_ff + 1'b1;
               end
            end
         end
         ST_CODE: begin
            have     = 1'b1;
            res_kind = lmrs_pkg::KIND_SHIFT;
            res_byte = code_ff[col_ff];
            if (can_load) begin
               if (col_ff == lmrs_pkg::COL_W'(lmrs_pkg::COLUMNS - 1)) begin
                  col_in = '0;
               end else begin
                  col_in = col_ff + 1'b1;
               end
               state_in = ST_LATCH;
            end
         end
         ST_LATCH: begin
            have     = 1'b1;
            res_kind = lmrs_pkg::KIND_LATCH;
            if (can_load) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            have     = 1'b1;
            res_last = 1'b1;
            res_kind = dimmer_enable ? lmrs_pkg::KIND_DELAY : lmrs_pkg::KIND_ON;
            if (can_load) begin
               if (dimmer_enable) begin
                  dim_in = 1'b1;
               end else begin
                  ready_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         blk_ff       <= '0;
         col_ff       <= '0;
         ready_ff     <= 1'b1;
         dim_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pat_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         blk_ff       <= blk_in;
         col_ff       <= col_in;
         ready_ff     <= ready_in;
         dim_ff       <= dim_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pat_we) begin
            pat_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pv_ff <= pat_valid_ff[rd_addr];
      if (code_we) begin
         code_ff[lmrs_pkg::COL_W'(head.entry.addr)] <= head.entry.data;
      end
      if (load) begin
         rsp_kind_ff <= res_kind;
         rsp_byte_ff <= res_byte;
         rsp_last_ff <= res_last;
      end
   end

   lmrs_ram #(
      .WIDTH (lmrs_pkg::DATA_W),
      .DEPTH (lmrs_pkg::PAT_DEPTH)
   ) u_pattern (
      .clock   (clock),
      .wr_en   (pat_we),
      .wr_addr (wr_addr),
      .wr_data (head.entry.data),
      .rd_addr (rd_addr),
      .rd_data (pat_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_shift_byte = rsp_byte_ff;
   assign rsp_last       = rsp_last_ff;

   `LMRS_ASSERT_NEVER(a_ready_and_waiting, ready_ff && dim_ff)
   `LMRS_ASSERT(a_busy_not_ready, (state_ff != ST_IDLE) |-> !ready_ff)
   `LMRS_ASSERT(a_last_ends_sequence, (load && res_last) |=> (state_ff == ST_IDLE))
   `LMRS_ASSERT(a_no_pop_mid_refresh, (state_ff != ST_IDLE) |-> !pop)

endmodule

[design/led_matrix_refresh_scanner.sv]
// top level of the column-multiplexed led matrix refresh scanner
// a tick's first result passes the queue, the state register and the result register
// a tick that starts a refresh gives BLOCKS+4 results, one result per cycle while rsp_stall
// is low; other requests are handled in the idle state without leaving it
// reset: queue and result register empty, pattern valid bits cleared at once, no sweep
// reset state: column zero, refresh ready, dimmer off and no delay pending
module led_matrix_refresh_scanner (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lmrs_pkg::CMD_W-1:0]   req_command,
   input  logic [lmrs_pkg::ADDR_W-1:0]  req_address,
   input  logic [lmrs_pkg::DATA_W-1:0]  req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lmrs_pkg::KIND_W-1:0]  rsp_kind,
   output logic [lmrs_pkg::DATA_W-1:0]  rsp_shift_byte,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_data
);

   lmrs_pkg::push_type push;
   lmrs_pkg::head_type head;
   logic               q_full;
   logic               pop;
   logic               dimmer_ff, dimmer_in;

   assign csr_ready = 1'b1;
   assign dimmer_in = (csr_valid && csr_ready) ? csr_data : dimmer_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dimmer_ff <= 1'b0;
      end else begin
         dimmer_ff <= dimmer_in;
      end
   end

   lmrs_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_address (req_address),
      .req_data    (req_data),
      .q_full      (q_full),
      .push        (push)
   );

   lmrs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (q_full),
      .head  (head)
   );

   lmrs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .dimmer_enable  (dimmer_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_shift_byte (rsp_shift_byte),
      .rsp_last       (rsp_last)
   );

endmodule

[tb/tb_led_matrix_refresh_scanner.sv]
// testbench for the led matrix refresh scanner: queued requests checked against a scan predictor
module tb_led_matrix_refresh_scanner;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_GAP       = 13;
   localparam int PHASE_ITEMS   = 46;

   typedef struct {
      logic [lmrs_pkg::KIND_W-1:0] kind;
      logic [lmrs_pkg::DATA_W-1:0] shift_byte;
      logic                        last;
   } scan_out_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [lmrs_pkg::CMD_W-1:0]  req_command = '0;
   logic [lmrs_pkg::ADDR_W-1:0] req_address = '0;
   logic [lmrs_pkg::DATA_W-1:0] req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [lmrs_pkg::KIND_W-1:0] rsp_kind;
   logic [lmrs_pkg::DATA_W-1:0] rsp_shift_byte;
   logic                        rsp_last;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic                        csr_data = 1'b0;

   // predictor state
   logic [lmrs_pkg::DATA_W-1:0] pat_mem [lmrs_pkg::PAT_DEPTH];
   logic [lmrs_pkg::DATA_W-1:0] code_mem [lmrs_pkg::COLUMNS];
   bit                          code_set [lmrs_pkg::COLUMNS];
   logic [lmrs_pkg::COL_W-1:0]  scan_col;
   bit                          scan_free;
   bit                          delay_pending;
   bit                          dim_on;

   lmrs_pkg::entry_type req_queue [$];
   scan_out_type        due_scan [$];

   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int mismatches = 0;
   int cycle_count = 0;

   led_matrix_refresh_scanner u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_address    (req_address),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_shift_byte (rsp_shift_byte),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   always #10 clock = ~clock;

   // applies one request to the predictor, returns 1 if it had any effect
   function automatic bit scan_predict(input lmrs_pkg::entry_type e);
      scan_out_type outs [$];
      scan_out_type r;
      int           b;
      bit           hit;
      hit = 1'b0;
      case (e.op)
         lmrs_pkg::OP_TICK: begin
            if (scan_free) begin
               hit = 1'b1;
               scan_free = 1'b0;
               r = '{lmrs_pkg::KIND_OFF, '0, 1'b0};
               outs.push_back(r);
               for (b = 0; b < lmrs_pkg::BLOCKS; b++) begin
                  r = '{lmrs_pkg::KIND_SHIFT,
                        ~pat_mem[b * lmrs_pkg::COLUMNS + int'(scan_col)], 1'b0};
                  outs.push_back(r);
               end
               r = '{lmrs_pkg::KIND_SHIFT, code_mem[scan_col], 1'b0};
               outs.push_back(r);
               scan_col = (int'(scan_col) == lmrs_pkg::COLUMNS - 1) ? '0 : scan_col + 1'b1;
               r = '{lmrs_pkg::KIND_LATCH, '0, 1'b0};
               outs.push_back(r);
               if (dim_on) begin
                  delay_pending = 1'b1;
                  r = '{lmrs_pkg::KIND_DELAY, '0, 1'b0};
               end else begin
                  scan_free = 1'b1;
                  r = '{lmrs_pkg::KIND_ON, '0, 1'b0};
               end
               outs.push_back(r);
            end
         end
         lmrs_pkg::OP_DELAY: begin
            if (delay_pending) begin
               hit = 1'b1;
               delay_pending = 1'b0;
               scan_free = 1'b1;
               r = '{lmrs_pkg::KIND_ON, '0, 1'b0};
               outs.push_back(r);
            end
         end
         lmrs_pkg::OP_PAT: begin
            if (int'(e.addr) < lmrs_pkg::PAT_DEPTH) begin
               hit = 1'b1;
               pat_mem[e.addr] = e.data;
            end
         end
         default: begin
            if (int'(e.addr) < lmrs_pkg::COLUMNS) begin
               hit = 1'b1;
               code_mem[e.addr[lmrs_pkg::COL_W-1:0]] = e.data;
               code_set[e.addr[lmrs_pkg::COL_W-1:0]] = 1'b1;
            end
         end
      endcase
      if (outs.size() != 0) outs[outs.size() - 1].last = 1'b1;
      foreach (outs[i]) due_scan.push_back(outs[i]);
      return hit;
   endfunction

   // queues a request; a tick that would read a never-written column code gets one first
   function automatic bit send_request(input lmrs_pkg::op_type op, input int addr,
                                       input int data);
      lmrs_pkg::entry_type e;
      if (op == lmrs_pkg::OP_TICK && scan_free && !code_set[scan_col]) begin
         e.op   = lmrs_pkg::OP_CODE;
         e.addr = lmrs_pkg::ADDR_W'(scan_col);
         e.data = lmrs_pkg::DATA_W'($urandom);
         void'(scan_predict(e));
         req_queue.push_back(e);
      end
      e.op   = op;
      e.addr = lmrs_pkg::ADDR_W'(addr);
      e.data = lmrs_pkg::DATA_W'(data);
      req_queue.push_back(e);
      return scan_predict(e);
   endfunction

   task automatic wait_idle();
      while (req_queue.size() != 0 || req_valid || due_scan.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input bit value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      dim_on = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin
      lmrs_pkg::entry_type e;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left--;
         end else if (req_queue.size() != 0) begin
            e = req_queue.pop_front();
            req_command <= e.op;
            req_address <= e.addr;
            req_data    <= e.data;
            req_valid   <= 1'b1;
            if ($urandom_range(0, 15) == 0) req_calm = !req_calm;
            gap_left = req_calm ? 0 : $urandom_range(0, MAX_GAP);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_taken) begin
            if ($urandom_range(0, 15) == 0) rsp_calm = !rsp_calm;
            stall_left = rsp_calm ? 0 : $urandom_range(0, MAX_GAP);
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // result monitor and cycle limit
   always @(posedge clock) begin
      scan_out_type want;
      req_taken <= !reset && req_valid && !req_stall;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILED: results differ");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         if (due_scan.size() == 0) begin
            mismatches++;
            $display("%0t: expected no result, got kind %0d byte %02h last %0b",
                     $time, rsp_kind, rsp_shift_byte, rsp_last);
         end else begin
            want = due_scan.pop_front();
            if (rsp_kind !== want.kind || rsp_shift_byte !== want.shift_byte ||
                rsp_last !== want.last) begin
               mismatches++;
               $display("%0t: expected kind %0d byte %02h last %0b, got %0d %02h %0b",
                        $time, want.kind, want.shift_byte, want.last,
                        rsp_kind, rsp_shift_byte, rsp_last);
            end
         end
      end
   end

   initial begin
      int phase;
      int done;
      int pick;
      int addr;
      foreach (pat_mem[i]) pat_mem[i] = '0;
      foreach (code_mem[i]) begin
         code_mem[i] = '0;
         code_set[i] = 1'b0;
      end
      scan_col      = '0;
      scan_free     = 1'b1;
      delay_pending = 1'b0;
      dim_on        = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: store extremes, dropped writes, dimmer off
      csr_write(1'b0);
      void'(send_request(lmrs_pkg::OP_CODE, 0, 8'h00));
      void'(send_request(lmrs_pkg::OP_CODE, 15, 8'hFF));
      void'(send_request(lmrs_pkg::OP_CODE, 127, 8'hA5));   // beyond the column table
      void'(send_request(lmrs_pkg::OP_PAT, 0, 8'hFF));
      void'(send_request(lmrs_pkg::OP_PAT, 127, 8'h00));
      void'(send_request(lmrs_pkg::OP_PAT, 16, 8'h5A));
      void'(send_request(lmrs_pkg::OP_TICK, 0, 0));
      void'(send_request(lmrs_pkg::OP_DELAY, 0, 0));        // nothing waiting
      void'(send_request(lmrs_pkg::OP_TICK, 127, 8'hFF));
      wait_idle();

      // dimmer on: delay start, tick while busy, delay release
      csr_write(1'b1);
      void'(send_request(lmrs_pkg::OP_TICK, 0, 0));
      void'(send_request(lmrs_pkg::OP_TICK, 0, 0));         // busy, dropped
      void'(send_request(lmrs_pkg::OP_PAT, 2, 8'h81));
      void'(send_request(lmrs_pkg::OP_DELAY, 0, 0));
      void'(send_request(lmrs_pkg::OP_DELAY, 0, 0));        // nothing waiting
      void'(send_request(lmrs_pkg::OP_TICK, 0, 0));
      wait_idle();

      // dimmer switched off while a refresh waits for its delay
      csr_write(1'b0);
      void'(send_request(lmrs_pkg::OP_TICK, 0, 0));
      void'(send_request(lmrs_pkg::OP_DELAY, 0, 0));
      void'(send_request(lmrs_pkg::OP_TICK, 0, 0));
      wait_idle();

      for (phase = 0; phase < 4; phase++) begin
         csr_write(phase == 3 ? 1'($urandom_range(0, 1)) : 1'(phase % 2 == 0));
         done = 0;
         while (done < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               void'(send_request(lmrs_pkg::OP_TICK, $urandom_range(0, 127),
                                  $urandom_range(0, 255)));
            end else if (pick < 52) begin
               void'(send_request(lmrs_pkg::OP_DELAY, $urandom_range(0, 127),
                                  $urandom_range(0, 255)));
            end else if (pick < 82) begin
               void'(send_request(lmrs_pkg::OP_PAT, $urandom_range(0, 127),
                                  $urandom_range(0, 255)));
            end else begin
               addr = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 127)
                                                  : $urandom_range(0, 15);
               void'(send_request(lmrs_pkg::OP_CODE, addr, $urandom_range(0, 255)));
            end
            done++;
         end
         wait_idle();
      end

      if (mismatches == 0 && due_scan.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
